/* rtl/core/triangle_unit_normal_assert.svh */
// Assertion macros shared by the checker.
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define TUN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("triangle_unit_normal check failed");

// next-cycle implication, sampled on aclk, off during reset
`define TUN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("triangle_unit_normal check failed");

`endif

/* rtl/core/tun_pkg.sv */
`default_nettype none
package tun_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_WIDTH     = NORMAL_FRAC_BITS + 2;
    localparam int NORMAL_ONE       = 2 ** NORMAL_FRAC_BITS;

    localparam int EDGE_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * EDGE_WIDTH;
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;
    localparam int MAG_WIDTH   = PROD_WIDTH;
    localparam int HALF_WIDTH  = MAG_WIDTH / 2;
    localparam int SQ_WIDTH    = 2 * MAG_WIDTH;
    localparam int SUM_WIDTH   = SQ_WIDTH + 2;
    localparam int K_SHIFT     = 2 * NORMAL_FRAC_BITS + 2;
    localparam int K_WIDTH     = SQ_WIDTH + K_SHIFT;
    localparam int ACC_WIDTH   = SUM_WIDTH + K_SHIFT + 3;
    localparam int Q_WIDTH     = NORMAL_FRAC_BITS + 1;
    localparam int NUM_CELLS   = NORMAL_FRAC_BITS + 1;
    localparam int LANES       = 3;

    // one normal component on its way through the cell chain
    typedef struct packed {
        logic                 neg;
        logic [K_WIDTH-1:0]   k;   // c^2 * 4^(F+1)
        logic [ACC_WIDTH-1:0] p;   // (2q-1)^2 * S
        logic [ACC_WIDTH-1:0] z;   // scaled (2q-1) * S, two's complement
        logic [Q_WIDTH-1:0]   q;
    } tun_lane_t;

    typedef struct packed {
        logic                       valid;
        logic                       degen;
        logic [ACC_WIDTH-1:0]       y;  // scaled S
        tun_lane_t [LANES-1:0]      lane;
    } tun_cell_t;

    typedef struct packed {
        logic [LANES-1:0][NORMAL_WIDTH-1:0] normal;
        logic                               degen;
    } tun_result_t;

endpackage
`default_nettype wire

/* rtl/core/tun_front.sv */
`default_nettype none
module tun_front (
    input  wire logic                                              aclk,
    input  wire logic                                              aresetn,
    input  wire logic                                              en,
    input  wire logic                                              in_valid,
    input  wire logic [tun_pkg::LANES-1:0][tun_pkg::COORD_WIDTH-1:0] pt_a,
    input  wire logic [tun_pkg::LANES-1:0][tun_pkg::COORD_WIDTH-1:0] pt_b,
    input  wire logic [tun_pkg::LANES-1:0][tun_pkg::COORD_WIDTH-1:0] pt_c,
    output tun_pkg::tun_cell_t                                     cell_out
);

    logic [5:0] v_reg;

    logic [tun_pkg::LANES-1:0][tun_pkg::EDGE_WIDTH-1:0]  e1_reg, e1_next, e2_reg, e2_next;
    logic [5:0][tun_pkg::PROD_WIDTH-1:0]                 prod_reg, prod_next;
    logic [tun_pkg::LANES-1:0][tun_pkg::CROSS_WIDTH-1:0] n_reg, n_next;
    logic [tun_pkg::LANES-1:0][tun_pkg::CROSS_WIDTH-1:0] n_abs;
    logic [tun_pkg::LANES-1:0][tun_pkg::MAG_WIDTH-1:0]   mag_reg, mag_next;
    logic [tun_pkg::LANES-1:0]                           neg4_reg, neg5_reg, neg6_reg;
    logic                                                degen4_reg, degen5_reg, degen6_reg;
    logic [tun_pkg::LANES-1:0][2*tun_pkg::HALF_WIDTH-1:0] hh_reg, hl_reg, ll_reg;
    logic [tun_pkg::LANES-1:0][2*tun_pkg::HALF_WIDTH-1:0] hh_next, hl_next, ll_next;
    logic [tun_pkg::LANES-1:0][tun_pkg::SQ_WIDTH-1:0]    sq_reg, sq_next;
    logic [tun_pkg::SUM_WIDTH-1:0]                       s_sum;
    tun_pkg::tun_cell_t                                  init_reg, init_next;

    always_comb begin
        for (int i = 0; i < tun_pkg::LANES; i++) begin
            e1_next[i] = {pt_b[i][tun_pkg::COORD_WIDTH-1], pt_b[i]}
                       - {pt_a[i][tun_pkg::COORD_WIDTH-1], pt_a[i]};
            e2_next[i] = {pt_c[i][tun_pkg::COORD_WIDTH-1], pt_c[i]}
                       - {pt_a[i][tun_pkg::COORD_WIDTH-1], pt_a[i]};
        end
    end

    // cross product terms: x = y1*z2 - z1*y2, y = z1*x2 - x1*z2, z = x1*y2 - y1*x2
    always_comb begin
        prod_next[0] = $signed(e1_reg[1]) * $signed(e2_reg[2]);
        prod_next[1] = $signed(e1_reg[2]) * $signed(e2_reg[1]);
        prod_next[2] = $signed(e1_reg[2]) * $signed(e2_reg[0]);
        prod_next[3] = $signed(e1_reg[0]) * $signed(e2_reg[2]);
        prod_next[4] = $signed(e1_reg[0]) * $signed(e2_reg[1]);
        prod_next[5] = $signed(e1_reg[1]) * $signed(e2_reg[0]);
    end

    always_comb begin
        for (int i = 0; i < tun_pkg::LANES; i++) begin
            n_next[i] = {prod_reg[2*i][tun_pkg::PROD_WIDTH-1], prod_reg[2*i]}
                      - {prod_reg[2*i+1][tun_pkg::PROD_WIDTH-1], prod_reg[2*i+1]};
            n_abs[i]  = n_reg[i][tun_pkg::CROSS_WIDTH-1] ? ('0 - n_reg[i]) : n_reg[i];
            mag_next[i] = n_abs[i][tun_pkg::MAG_WIDTH-1:0];
        end
    end

    // squares from three half-width partial products
    always_comb begin
        for (int i = 0; i < tun_pkg::LANES; i++) begin
            hh_next[i] = mag_reg[i][tun_pkg::MAG_WIDTH-1:tun_pkg::HALF_WIDTH]
                       * mag_reg[i][tun_pkg::MAG_WIDTH-1:tun_pkg::HALF_WIDTH];
            hl_next[i] = mag_reg[i][tun_pkg::MAG_WIDTH-1:tun_pkg::HALF_WIDTH]
                       * mag_reg[i][tun_pkg::HALF_WIDTH-1:0];
            ll_next[i] = mag_reg[i][tun_pkg::HALF_WIDTH-1:0]
                       * mag_reg[i][tun_pkg::HALF_WIDTH-1:0];
            sq_next[i] = {hh_reg[i], {(2*tun_pkg::HALF_WIDTH){1'b0}}}
                       + {{(tun_pkg::HALF_WIDTH-1){1'b0}}, hl_reg[i],
                          {(tun_pkg::HALF_WIDTH+1){1'b0}}}
                       + {{(2*tun_pkg::HALF_WIDTH){1'b0}}, ll_reg[i]};
        end
    end

    // recurrence start: q = 0, so u = -1, P = S, Q = -S
    always_comb begin
        s_sum = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
        init_next.valid = v_reg[5];
        init_next.degen = degen6_reg;
        init_next.y = {3'b000, s_sum, {tun_pkg::K_SHIFT{1'b0}}};
        for (int i = 0; i < tun_pkg::LANES; i++) begin
            init_next.lane[i].neg = neg6_reg[i];
            init_next.lane[i].k   = {sq_reg[i], {tun_pkg::K_SHIFT{1'b0}}};
            init_next.lane[i].p   = {{(tun_pkg::ACC_WIDTH-tun_pkg::SUM_WIDTH){1'b0}}, s_sum};
            init_next.lane[i].z   = '0 - {{(tun_pkg::K_SHIFT-tun_pkg::NORMAL_FRAC_BITS+1){1'b0}},
                                          s_sum, {(tun_pkg::NORMAL_FRAC_BITS+2){1'b0}}};
            init_next.lane[i].q   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg          <= '0;
            init_reg.valid <= 1'b0;
        end else if (en) begin
            v_reg    <= {v_reg[4:0], in_valid};
            init_reg <= init_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg     <= e1_next;
            e2_reg     <= e2_next;
            prod_reg   <= prod_next;
            n_reg      <= n_next;
            mag_reg    <= mag_next;
            for (int i = 0; i < tun_pkg::LANES; i++) begin
                neg4_reg[i] <= n_reg[i][tun_pkg::CROSS_WIDTH-1];
            end
            degen4_reg <= (n_reg == '0);
            hh_reg     <= hh_next;
            hl_reg     <= hl_next;
            ll_reg     <= ll_next;
            neg5_reg   <= neg4_reg;
            degen5_reg <= degen4_reg;
            sq_reg     <= sq_next;
            neg6_reg   <= neg5_reg;
            degen6_reg <= degen5_reg;
        end
    end

    assign cell_out = init_reg;

endmodule
`default_nettype wire

/* rtl/core/tun_cell.sv */
`default_nettype none
// One quotient bit for all three lanes. Keeps P = (2q-1)^2*S against K with
// shifts and adds only; Y and Z are rescaled by 4 and 2 on the way out.
module tun_cell (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  tun_pkg::tun_cell_t cell_in,
    output tun_pkg::tun_cell_t cell_out
);

    tun_pkg::tun_cell_t                                   cell_reg, cell_next;
    logic [tun_pkg::LANES-1:0][tun_pkg::ACC_WIDTH-1:0]    trial, z_upd;
    logic [tun_pkg::LANES-1:0]                            ok;

    always_comb begin
        cell_next       = cell_in;
        cell_next.y     = {2'b00, cell_in.y[tun_pkg::ACC_WIDTH-1:2]};
        for (int i = 0; i < tun_pkg::LANES; i++) begin
            trial[i] = cell_in.lane[i].p + cell_in.lane[i].z + cell_in.y;
            ok[i]    = $signed(trial[i]) <= $signed({{(tun_pkg::ACC_WIDTH-tun_pkg::K_WIDTH){1'b0}},
                                                     cell_in.lane[i].k});
            z_upd[i] = ok[i] ? (cell_in.lane[i].z + {cell_in.y[tun_pkg::ACC_WIDTH-2:0], 1'b0})
                             : cell_in.lane[i].z;
            cell_next.lane[i].p = ok[i] ? trial[i] : cell_in.lane[i].p;
            cell_next.lane[i].z = {z_upd[i][tun_pkg::ACC_WIDTH-1],
                                   z_upd[i][tun_pkg::ACC_WIDTH-1:1]};
            cell_next.lane[i].q = {cell_in.lane[i].q[tun_pkg::Q_WIDTH-2:0], ok[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule
`default_nettype wire

/* rtl/core/tun_out.sv */
`default_nettype none
// Output register plus one skid entry; the chain runs while the skid is empty.
module tun_out (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  tun_pkg::tun_cell_t cell_in,
    output logic               en,
    output logic               m_valid,
    input  wire logic          m_ready,
    output tun_pkg::tun_result_t result
);

    tun_pkg::tun_result_t                    res_next, out_reg, skid_reg;
    logic                                    out_valid_reg, skid_full_reg;
    logic [tun_pkg::NORMAL_WIDTH-1:0]        mag [tun_pkg::LANES];
    logic                                    incoming, out_free;

    always_comb begin
        res_next.degen = cell_in.degen;
        for (int i = 0; i < tun_pkg::LANES; i++) begin
            mag[i] = {1'b0, cell_in.lane[i].q};
            if (cell_in.degen) begin
                res_next.normal[i] = '0;
            end else if (cell_in.lane[i].neg) begin
                res_next.normal[i] = '0 - mag[i];
            end else begin
                res_next.normal[i] = mag[i];
            end
        end
    end

    assign en       = !skid_full_reg;
    assign incoming = cell_in.valid && en;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (out_free) begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end
        end else if (incoming) begin
            if (out_free) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_full_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (out_free) begin
                out_reg <= skid_reg;
            end
        end else if (incoming) begin
            if (out_free) begin
                out_reg <= res_next;
            end else begin
                skid_reg <= res_next;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = out_reg;

endmodule
`default_nettype wire

/* rtl/core/triangle_unit_normal.sv */
`default_nettype none
// Unit face normal of a triangle.
// Input channel (s_valid/s_ready): corners A, B, C, signed 16-bit coordinates.
// Result channel (m_valid/m_ready): normal_x/y/z in signed Q1.14, rounded to
// nearest with ties away from zero, plus a degenerate flag that is set (with a
// zero vector) when the cross product is zero.
// From the accepting edge until m_valid rises, data passes seven front
// stages (edges, products, cross, magnitude, partial squares, squares, sum),
// a chain of 15 bit cells, one per quotient bit, and the output register.
// Throughput: one transaction per cycle while s_ready is high; every stage
// and cell is registered. The result side has an output register and one
// skid entry. When the receiver stalls, the skid takes the next finished
// transaction and then s_ready drops and the whole chain holds until the
// receiver takes data again. Reset (aresetn low, synchronous) empties the
// pipeline; s_ready is high and m_valid low after reset.
module triangle_unit_normal (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0] s_point_a_x,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0] s_point_a_y,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0] s_point_a_z,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0] s_point_b_x,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0] s_point_b_y,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0] s_point_b_z,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0] s_point_c_x,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0] s_point_c_y,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0] s_point_c_z,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [tun_pkg::NORMAL_WIDTH-1:0]     m_normal_x,
    output logic signed [tun_pkg::NORMAL_WIDTH-1:0]     m_normal_y,
    output logic signed [tun_pkg::NORMAL_WIDTH-1:0]     m_normal_z,
    output logic                                        m_degenerate
);

    logic                 en;
    tun_pkg::tun_cell_t   chain [tun_pkg::NUM_CELLS+1];
    tun_pkg::tun_result_t result;

    tun_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .pt_a     ({s_point_a_z, s_point_a_y, s_point_a_x}),
        .pt_b     ({s_point_b_z, s_point_b_y, s_point_b_x}),
        .pt_c     ({s_point_c_z, s_point_c_y, s_point_c_x}),
        .cell_out (chain[0])
    );

    for (genvar g = 0; g < tun_pkg::NUM_CELLS; g++) begin : g_cell
        tun_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    tun_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cell_in (chain[tun_pkg::NUM_CELLS]),
        .en      (en),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .result  (result)
    );

    assign s_ready      = en;
    assign m_normal_x   = result.normal[0];
    assign m_normal_y   = result.normal[1];
    assign m_normal_z   = result.normal[2];
    assign m_degenerate = result.degen;

endmodule
`default_nettype wire

/* rtl/core/tun_checker.sv */
`default_nettype none
`include "triangle_unit_normal_assert.svh"
module tun_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic [tun_pkg::NORMAL_WIDTH-1:0]   m_normal_x,
    input wire logic [tun_pkg::NORMAL_WIDTH-1:0]   m_normal_y,
    input wire logic [tun_pkg::NORMAL_WIDTH-1:0]   m_normal_z,
    input wire logic                               m_degenerate
);

    `TUN_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_normal_x) && $stable(m_normal_y) && $stable(m_normal_z) && $stable(m_degenerate))
    `TUN_ASSERT_NOW(a_degen_zero, m_valid && m_degenerate, m_normal_x == '0 && m_normal_y == '0 && m_normal_z == '0)
    `TUN_ASSERT_NOW(a_nondegen_nonzero, m_valid && !m_degenerate, m_normal_x != '0 || m_normal_y != '0 || m_normal_z != '0)
    `TUN_ASSERT_NOW(a_x_range, m_valid, $signed(m_normal_x) <= tun_pkg::NORMAL_ONE && $signed(m_normal_x) >= -tun_pkg::NORMAL_ONE)

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (.*);
`default_nettype wire
